// ----- rtl/core/hmtp_pkg.sv -----
package hmtp_pkg;

	localparam int unsigned MAX_CELLS        = 1048576;
	localparam int unsigned MAX_NUMBER_CHARS = 11;

	localparam int unsigned CHAR_W       = 8;
	localparam int unsigned IDX_W        = 20;
	localparam int unsigned HGT_W        = 32;
	localparam int unsigned COL_W        = 8;
	localparam int unsigned MAXH_W       = 31;
	localparam int unsigned LIMIT_W      = 21;
	localparam int unsigned LIM_CMP_W    = 25;
	localparam int unsigned CNT_W        = 4;
	localparam int unsigned CHAN_W       = 3;
	localparam int unsigned NUM_CHANNELS = 4;
	localparam int unsigned CHAN_IDX_W   = $clog2(NUM_CHANNELS);

	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2c;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UP_F  = 8'h46;
	localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LO_F  = 8'h66;
	localparam logic [CHAR_W-1:0] CH_X     = 8'h78;

	typedef logic [COL_W-1:0] colour_t;

	localparam colour_t COLOUR_DEFAULT [NUM_CHANNELS] = '{8'd255, 8'd140, 8'd0, 8'd255};

	typedef struct packed {
		logic              ok;
		logic [3:0]        val;
	} hex_t;

	typedef struct packed {
		logic [IDX_W-1:0]         cell_index;
		logic signed [HGT_W-1:0]  height_value;
		colour_t                  red;
		colour_t                  green;
		colour_t                  blue;
		colour_t                  alpha;
		logic [MAXH_W-1:0]        running_max_height;
	} cell_t;

	function automatic hex_t hex_decode(input logic [CHAR_W-1:0] c);
		hex_t r;
		r = '0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			r.ok  = 1'b1;
			r.val = c[3:0];
		end else if ((c >= CH_LO_A && c <= CH_LO_F) || (c >= CH_UP_A && c <= CH_UP_F)) begin
			r.ok  = 1'b1;
			r.val = c[3:0] + 4'd9;
		end
		return r;
	endfunction

endpackage

// ----- rtl/core/hmtp_char_if.sv -----
interface hmtp_char_if import hmtp_pkg::*;;
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_code;

	modport source(output valid, output char_code, input ready);
	modport sink(input valid, input char_code, output ready);
endinterface

// ----- rtl/core/hmtp_cell_if.sv -----
interface hmtp_cell_if import hmtp_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic [IDX_W-1:0]         cell_index;
	logic signed [HGT_W-1:0]  height_value;
	logic [COL_W-1:0]         red;
	logic [COL_W-1:0]         green;
	logic [COL_W-1:0]         blue;
	logic [COL_W-1:0]         alpha;
	logic [MAXH_W-1:0]        running_max_height;

	modport source(output valid, output cell_index, output height_value, output red,
		output green, output blue, output alpha, output running_max_height, input ready);
	modport sink(input valid, input cell_index, input height_value, input red,
		input green, input blue, input alpha, input running_max_height, output ready);
endinterface

// ----- rtl/core/hmtp_in_reg.sv -----
module hmtp_in_reg import hmtp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	hmtp_char_if.sink         text,
	input  logic              take,
	output logic              valid_s1,
	output logic [CHAR_W-1:0] char_s1
);

	logic load;

	assign text.ready = !valid_s1 || take;
	assign load       = text.valid && text.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			char_s1 <= text.char_code;
		end
	end

endmodule

// ----- rtl/core/hmtp_parse.sv -----
module hmtp_parse import hmtp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [LIMIT_W-1:0] cfg_wr_data,
	input  logic               valid_s1,
	input  logic [CHAR_W-1:0]  char_s1,
	input  logic               out_free,
	output logic               take,
	output logic               emit,
	output cell_t              cell_d
);

	typedef enum logic [2:0] {
		PH_BETWEEN,
		PH_NUMBER,
		PH_COMMA,
		PH_ZERO,
		PH_HEX_HIGH,
		PH_HEX_LOW,
		PH_SKIP,
		PH_STRAY
	} phase_t;

	localparam logic [LIM_CMP_W-1:0] MAX_CELLS_CMP = LIM_CMP_W'(MAX_CELLS);

	phase_t              phase_q, phase_d;
	logic [HGT_W-1:0]    acc_q, acc_d;
	logic                neg_q, neg_d;
	logic                stop_q, stop_d;
	logic [CNT_W-1:0]    cnt_q, cnt_d;
	logic [CHAN_W-1:0]   chan_q, chan_d;
	logic [3:0]          nib_q, nib_d;
	colour_t             col_q [NUM_CHANNELS];
	colour_t             col_d [NUM_CHANNELS];
	logic [LIMIT_W-1:0]  cell_limit_q;
	logic [LIMIT_W-1:0]  cell_cnt_q;
	logic [MAXH_W-1:0]   max_q, max_d;

	logic                is_digit, is_minus, is_ws, ends, in_token, room;
	hex_t                hx;
	logic [HGT_W-1:0]    acc_x10;
	logic [HGT_W-1:0]    h;
	logic [LIM_CMP_W-1:0] limit_ext, limit_eff;

	assign is_digit = (char_s1 >= CH_ZERO) && (char_s1 <= CH_NINE);
	assign is_minus = (char_s1 == CH_MINUS);
	assign is_ws    = (char_s1 == CH_SPACE) || ((char_s1 >= CH_TAB) && (char_s1 <= CH_CR));
	assign ends     = (char_s1 == CH_NUL) || is_ws;
	assign hx       = hex_decode(char_s1);
	assign acc_x10  = {acc_q[HGT_W-4:0], 3'b000} + {acc_q[HGT_W-2:0], 1'b0}
		+ {{(HGT_W-4){1'b0}}, char_s1[3:0]};

	assign in_token  = (phase_q != PH_BETWEEN) && (phase_q != PH_STRAY);
	assign limit_ext = {{(LIM_CMP_W-LIMIT_W){1'b0}}, cell_limit_q};
	assign limit_eff = (limit_ext < MAX_CELLS_CMP) ? limit_ext : MAX_CELLS_CMP;
	assign room      = {{(LIM_CMP_W-LIMIT_W){1'b0}}, cell_cnt_q} < limit_eff;

	assign emit = valid_s1 && in_token && ends && room;
	assign take = valid_s1 && (!emit || out_free);

	// height and running max
	assign h = neg_q ? (~acc_q + 1'b1) : acc_q;

	always_comb begin
		max_d = max_q;
		if (!h[HGT_W-1] && (h[MAXH_W-1:0] > max_q)) begin
			max_d = h[MAXH_W-1:0];
		end
	end

	always_comb begin
		cell_d.cell_index         = cell_cnt_q[IDX_W-1:0];
		cell_d.height_value       = h;
		cell_d.red                = col_q[0];
		cell_d.green              = col_q[1];
		cell_d.blue               = col_q[2];
		cell_d.alpha              = col_q[3];
		cell_d.running_max_height = max_d;
	end

	always_comb begin
		phase_d = phase_q;
		acc_d   = acc_q;
		neg_d   = neg_q;
		stop_d  = stop_q;
		cnt_d   = cnt_q;
		chan_d  = chan_q;
		nib_d   = nib_q;
		col_d   = col_q;
		unique case (phase_q)
			PH_BETWEEN: begin
				if (is_digit || is_minus) begin
					neg_d   = is_minus;
					acc_d   = is_minus ? '0 : {{(HGT_W-4){1'b0}}, char_s1[3:0]};
					stop_d  = 1'b0;
					cnt_d   = CNT_W'(1);
					chan_d  = '0;
					nib_d   = '0;
					col_d   = COLOUR_DEFAULT;
					phase_d = PH_NUMBER;
				end else if (!ends) begin
					phase_d = PH_STRAY;
				end
			end
			PH_STRAY: begin
				if (ends) begin
					phase_d = PH_BETWEEN;
				end
			end
			default: begin
				if (ends) begin
					phase_d = PH_BETWEEN;
				end else begin
					case (phase_q)
						PH_NUMBER: begin
							if (is_digit || is_minus) begin
								if (cnt_q < CNT_W'(MAX_NUMBER_CHARS)) begin
									if (!stop_q && is_digit) begin
										acc_d = acc_x10;
									end else begin
										stop_d = 1'b1;
									end
									cnt_d = cnt_q + 1'b1;
								end
							end else begin
								phase_d = (char_s1 == CH_COMMA) ? PH_COMMA : PH_SKIP;
							end
						end
						PH_COMMA: phase_d = (char_s1 == CH_ZERO) ? PH_ZERO : PH_SKIP;
						PH_ZERO:  phase_d = (char_s1 == CH_X) ? PH_HEX_HIGH : PH_SKIP;
						PH_HEX_HIGH: begin
							if (!hx.ok || (chan_q >= CHAN_W'(NUM_CHANNELS))) begin
								phase_d = PH_SKIP;
							end else begin
								nib_d   = hx.val;
								phase_d = PH_HEX_LOW;
							end
						end
						PH_HEX_LOW: begin
							if (!hx.ok) begin
								phase_d = PH_SKIP;
							end else begin
								col_d[chan_q[CHAN_IDX_W-1:0]] = {nib_q, hx.val};
								chan_d  = chan_q + 1'b1;
								phase_d = PH_HEX_HIGH;
							end
						end
						default: ;
					endcase
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_BETWEEN;
			acc_q        <= '0;
			neg_q        <= 1'b0;
			stop_q       <= 1'b0;
			cnt_q        <= '0;
			chan_q       <= '0;
			nib_q        <= '0;
			col_q        <= COLOUR_DEFAULT;
			cell_limit_q <= '0;
			cell_cnt_q   <= '0;
			max_q        <= '0;
		end else begin
			if (cfg_wr_en) begin
				cell_limit_q <= cfg_wr_data;
			end
			if (take) begin
				phase_q <= phase_d;
				acc_q   <= acc_d;
				neg_q   <= neg_d;
				stop_q  <= stop_d;
				cnt_q   <= cnt_d;
				chan_q  <= chan_d;
				nib_q   <= nib_d;
				col_q   <= col_d;
			end
			if (take && emit) begin
				cell_cnt_q <= cell_cnt_q + 1'b1;
				max_q      <= max_d;
			end
		end
	end

endmodule

// ----- rtl/core/hmtp_out_reg.sv -----
module hmtp_out_reg import hmtp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  cell_t      cell_d,
	output logic       out_free,
	hmtp_cell_if.source map_cell
);

	logic  valid_q;
	cell_t cell_q;

	assign out_free = !valid_q || map_cell.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && out_free) begin
			cell_q <= cell_d;
		end
	end

	assign map_cell.valid              = valid_q;
	assign map_cell.cell_index         = cell_q.cell_index;
	assign map_cell.height_value       = cell_q.height_value;
	assign map_cell.red                = cell_q.red;
	assign map_cell.green              = cell_q.green;
	assign map_cell.blue               = cell_q.blue;
	assign map_cell.alpha              = cell_q.alpha;
	assign map_cell.running_max_height = cell_q.running_max_height;

endmodule

// ----- rtl/core/height_map_token_parser.sv -----
// Height-map text parser.
// text: one byte of map text per word (valid/ready). Whitespace separates
//   tokens; a zero byte ends the current token like whitespace.
// map_cell: one word per completed token: index, height, RGBA and running max.
// cfg_wr_en/cfg_wr_data: writes cell_limit; write only while idle.
// Throughput: one text byte per cycle unless a token-ending byte waits (see
//   Stall). A byte is registered on entry, parsed from the input register,
//   and a completed cell is registered into the map_cell output register.
// Stall: the cell register holds its word while map_cell.ready is low; bytes
//   that do not end a token keep flowing, a token-ending byte waits in the
//   input register until the cell register frees.
// Reset (arst_n low): parser returns to between-tokens, cell count and
//   running max clear, cell_limit is 0 so no cells emit until it is written.
module height_map_token_parser import hmtp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [LIMIT_W-1:0] cfg_wr_data,
	hmtp_char_if.sink          text,
	hmtp_cell_if.source        map_cell
);

	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              take;
	logic              emit;
	logic              out_free;
	cell_t             cell_d;

	hmtp_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.text     (text),
		.take     (take),
		.valid_s1 (valid_s1),
		.char_s1  (char_s1)
	);

	hmtp_parse u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.valid_s1    (valid_s1),
		.char_s1     (char_s1),
		.out_free    (out_free),
		.take        (take),
		.emit        (emit),
		.cell_d      (cell_d)
	);

	hmtp_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (emit && take),
		.cell_d   (cell_d),
		.out_free (out_free),
		.map_cell (map_cell)
	);

endmodule

// ----- verif/tb_height_map_token_parser.sv -----
module tb_height_map_token_parser;
	timeunit 1ns;
	timeprecision 1ps;
	import hmtp_pkg::*;

	typedef enum logic [2:0] {
		TOK_IDLE, TOK_DIGITS, TOK_COMMA, TOK_ZERO, TOK_HEX_HI, TOK_HEX_LO, TOK_JUNK, TOK_STRAY
	} tok_state_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_wr_en;
	logic [LIMIT_W-1:0] cfg_wr_data;

	hmtp_char_if text_if();
	hmtp_cell_if cell_if();

	height_map_token_parser i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.text       (text_if),
		.map_cell   (cell_if)
	);

	// parser shadow state
	tok_state_t         tok_state = TOK_IDLE;
	logic [HGT_W-1:0]   num_acc = '0;
	logic               num_neg = 1'b0;
	logic               num_halt = 1'b0;
	int unsigned        num_chars = 0;
	int unsigned        chan_sel = 0;
	logic [3:0]         hi_nib = '0;
	colour_t            rgba [NUM_CHANNELS] = COLOUR_DEFAULT;
	logic [LIMIT_W-1:0] cell_limit_model = '0;
	logic [LIMIT_W-1:0] cells_made = '0;
	logic signed [HGT_W-1:0] peak_height = '0;

	cell_t       cells_due[$];
	logic [7:0]  text_q[$];
	int          err_count = 0;
	int          bytes_made = 0;
	logic        byte_taken = 1'b0;
	int          send_gap = 0;
	int          take_gap = 0;
	int          calm_tx = 0;
	int          calm_rx = 0;
	string       hex_set = "0123456789abcdefABCDEF";

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic bit is_space(input logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic bit is_digit(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic int nibble_of(input logic [7:0] c);
		if (is_digit(c))
			return int'(c - CH_ZERO);
		if (c >= CH_LO_A && c <= CH_LO_F)
			return int'(c - CH_LO_A) + 10;
		if (c >= CH_UP_A && c <= CH_UP_F)
			return int'(c - CH_UP_A) + 10;
		return -1;
	endfunction

	task automatic add_height_char(input logic [7:0] c);
		if (num_chars >= MAX_NUMBER_CHARS)
			return;
		if (num_chars == 0 && c == CH_MINUS)
			num_neg = 1'b1;
		else if (!num_halt && is_digit(c))
			num_acc = num_acc * 32'd10 + 32'(c - CH_ZERO);
		else
			num_halt = 1'b1;
		num_chars++;
	endtask

	task automatic close_token();
		cell_t            w;
		logic [HGT_W-1:0] h;
		tok_state = TOK_IDLE;
		if (cells_made < cell_limit_model && cells_made < MAX_CELLS) begin
			h = num_neg ? -num_acc : num_acc;
			if ($signed(h) > peak_height)
				peak_height = h;
			w.cell_index         = cells_made[IDX_W-1:0];
			w.height_value       = h;
			w.red                = rgba[0];
			w.green              = rgba[1];
			w.blue               = rgba[2];
			w.alpha              = rgba[3];
			w.running_max_height = peak_height[MAXH_W-1:0];
			cells_due.push_back(w);
			cells_made++;
		end
	endtask

	task automatic parse_char(input logic [7:0] c);
		bit ends;
		int hv;
		ends = c == CH_NUL || is_space(c);
		hv   = nibble_of(c);
		case (tok_state)
			TOK_IDLE: begin
				if (is_digit(c) || c == CH_MINUS) begin
					num_acc   = '0;
					num_neg   = 1'b0;
					num_halt  = 1'b0;
					num_chars = 0;
					chan_sel  = 0;
					hi_nib    = '0;
					rgba      = COLOUR_DEFAULT;
					add_height_char(c);
					tok_state = TOK_DIGITS;
				end else if (!ends) begin
					tok_state = TOK_STRAY;
				end
			end
			TOK_STRAY: begin
				if (ends)
					tok_state = TOK_IDLE;
			end
			default: begin
				if (ends) begin
					close_token();
				end else begin
					case (tok_state)
						TOK_DIGITS: begin
							if (is_digit(c) || c == CH_MINUS)
								add_height_char(c);
							else if (c == CH_COMMA)
								tok_state = TOK_COMMA;
							else
								tok_state = TOK_JUNK;
						end
						TOK_COMMA: begin
							if (c == CH_ZERO)
								tok_state = TOK_ZERO;
							else
								tok_state = TOK_JUNK;
						end
						TOK_ZERO: begin
							if (c == CH_X)
								tok_state = TOK_HEX_HI;
							else
								tok_state = TOK_JUNK;
						end
						TOK_HEX_HI: begin
							if (hv < 0 || chan_sel >= NUM_CHANNELS) begin
								tok_state = TOK_JUNK;
							end else begin
								hi_nib    = hv[3:0];
								tok_state = TOK_HEX_LO;
							end
						end
						TOK_HEX_LO: begin
							if (hv < 0) begin
								tok_state = TOK_JUNK;
							end else begin
								rgba[chan_sel[1:0]] = {hi_nib, hv[3:0]};
								chan_sel++;
								tok_state = TOK_HEX_HI;
							end
						end
						default: ;
					endcase
				end
			end
		endcase
	endtask

	task automatic check_field(input string field, input longint want, input longint seen);
		if (want != seen) begin
			$error("%s: expected %0d, got %0d", field, want, seen);
			err_count++;
		end
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 50);
	endfunction

	// monitor: cells first, so a cell never meets an expectation pushed at the same edge
	always @(posedge clk) begin
		cell_t want;
		byte_taken <= text_if.valid && text_if.ready;
		if (cfg_wr_en)
			cell_limit_model = cfg_wr_data;
		if (arst_n && cell_if.valid && cell_if.ready) begin
			if (cells_due.size() == 0) begin
				$error("cell word with no expectation, cell_index %0d", cell_if.cell_index);
				err_count++;
			end else begin
				want = cells_due.pop_front();
				check_field("cell_index", want.cell_index, cell_if.cell_index);
				check_field("height_value", want.height_value, cell_if.height_value);
				check_field("red", want.red, cell_if.red);
				check_field("green", want.green, cell_if.green);
				check_field("blue", want.blue, cell_if.blue);
				check_field("alpha", want.alpha, cell_if.alpha);
				check_field("running_max_height", want.running_max_height,
					cell_if.running_max_height);
			end
		end
		if (arst_n && text_if.valid && text_if.ready)
			parse_char(text_if.char_code);
	end

	// text driver
	always @(negedge clk) begin
		if (text_if.valid && !byte_taken) begin
			// word still waiting
		end else if (!arst_n || send_gap > 0 || text_q.size() == 0) begin
			if (send_gap > 0)
				send_gap--;
			text_if.valid <= 1'b0;
		end else begin
			text_if.valid     <= 1'b1;
			text_if.char_code <= text_q.pop_front();
			send_gap = (calm_tx > 0) ? 0 : pick_gap();
		end
		if (calm_tx > 0)
			calm_tx--;
		else if ($urandom_range(0, 199) == 0)
			calm_tx = 150;
	end

	// cell sink
	always @(negedge clk) begin
		if (take_gap > 0) begin
			take_gap--;
			cell_if.ready <= 1'b0;
		end else begin
			cell_if.ready <= 1'b1;
			take_gap = (calm_rx > 0) ? 0 : pick_gap();
		end
		if (calm_rx > 0)
			calm_rx--;
		else if ($urandom_range(0, 199) == 0)
			calm_rx = 150;
	end

	task automatic put_char(input logic [7:0] c);
		text_q.push_back(c);
		bytes_made++;
	endtask

	task automatic put_str(input string s);
		for (int i = 0; i < s.len(); i++)
			put_char(s[i]);
	endtask

	function automatic logic [7:0] rand_hex();
		return hex_set[$urandom_range(0, hex_set.len() - 1)];
	endfunction

	function automatic logic [7:0] rand_space();
		if ($urandom_range(0, 2) == 0)
			return CH_SPACE;
		return CH_TAB + 8'($urandom_range(0, 4));
	endfunction

	task automatic put_token();
		int          kind;
		int          ndig;
		int          npairs;
		logic [7:0]  c;
		kind = $urandom_range(0, 99);
		if (kind < 6) begin
			// stray word
			do
				c = 8'($urandom_range(33, 255));
			while (is_digit(c) || c == CH_MINUS);
			put_char(c);
			repeat ($urandom_range(0, 4))
				put_char(8'($urandom_range(33, 126)));
		end else if (kind < 10) begin
			repeat ($urandom_range(1, 3))
				put_char(8'($urandom_range(0, 255)));
		end else begin
			if ($urandom_range(0, 9) == 0)
				put_char(CH_MINUS);
			kind = $urandom_range(0, 99);
			if (kind < 70)
				ndig = $urandom_range(1, 4);
			else if (kind < 90)
				ndig = $urandom_range(8, 10);
			else
				ndig = $urandom_range(11, 14);
			for (int i = 0; i < ndig; i++) begin
				if ($urandom_range(0, 29) == 0)
					put_char(CH_MINUS);
				else
					put_char(CH_ZERO + 8'($urandom_range(0, 9)));
			end
			if ($urandom_range(0, 9) < 6) begin
				put_char(($urandom_range(0, 15) == 0) ? rand_hex() : CH_COMMA);
				put_char(($urandom_range(0, 15) == 0) ? CH_X : CH_ZERO);
				put_char(($urandom_range(0, 11) == 0) ? CH_UP_A + 8'd23 : CH_X);
				npairs = $urandom_range(0, 5);
				for (int i = 0; i < npairs; i++) begin
					put_char(rand_hex());
					if ($urandom_range(0, 19) == 0)
						put_char(8'($urandom_range(33, 255)));
					put_char(rand_hex());
				end
				if ($urandom_range(0, 7) == 0)
					put_char(rand_hex());
			end
		end
		kind = $urandom_range(0, 99);
		if (kind < 80) begin
			put_char(rand_space());
		end else if (kind < 92) begin
			put_char(rand_space());
			put_char(rand_space());
		end else if (kind < 97) begin
			put_char(CH_NUL);
		end
	endtask

	task automatic put_random(input int n);
		int goal;
		goal = bytes_made + n;
		while (bytes_made < goal)
			put_token();
	endtask

	task automatic wait_idle();
		while (text_q.size() != 0 || text_if.valid || cells_due.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_limit(input logic [LIMIT_W-1:0] v);
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	initial begin
		arst_n            = 1'b0;
		cfg_wr_en         = 1'b0;
		cfg_wr_data       = '0;
		text_if.valid     = 1'b0;
		text_if.char_code = '0;
		cell_if.ready     = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// limit is 0 out of reset: nothing may emit
		put_str("7 -3\n");
		wait_idle();

		write_limit({LIMIT_W{1'b1}});
		put_str("-2147483648,0xfFA0 99999999999 - x\t");
		put_char(CH_NUL);
		put_random(500);
		wait_idle();

		write_limit(LIMIT_W'(cells_made + LIMIT_W'(6)));
		put_random(250);
		wait_idle();

		write_limit(LIMIT_W'(MAX_CELLS));
		put_random(300);
		wait_idle();

		write_limit('0);
		put_random(50);
		wait_idle();

		if (err_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

endmodule
